// File: sv/stfe_pkg.sv
`default_nettype none

package stfe_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;
  localparam int INDEX_BITS_DEF       = 24;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 31;
  localparam int NOTE_LEN_W = 24;
  localparam int GAIN_W     = 16;
  localparam int MAG_W      = 15;
  localparam int QUOT_W     = 16;
  localparam int DIVIDEND_W = 2 * QUOT_W;
  localparam int Q_FRAC     = 15;
  // phase bits below this are dropped before the table address is scaled
  localparam int PHASE_DROP = 16;

  localparam logic [GAIN_W-1:0]   FULL_SCALE = 16'h8000;
  localparam logic [QUOT_W-1:0]   PEAK       = 16'h7FFF;
  localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;

  localparam int REG_ADDR_W = 3;

  typedef enum logic {
    REG_AMPLITUDE = 1'b0,
    REG_FADE_LEN  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  first_of_note;
    logic [STEP_W-1:0]     phase_step;
    logic [NOTE_LEN_W-1:0] note_len;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_note;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/stfe_state_mem.sv
`default_nettype none

module stfe_state_mem #(
  parameter int INDEX_BITS = 24,
  parameter int PHASE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en,
  input  wire logic                  wr_en,
  input  wire logic [INDEX_BITS-1:0] wr_idx,
  input  wire logic [PHASE_BITS-1:0] wr_phase,
  output logic      [INDEX_BITS-1:0] rd_idx,
  output logic      [PHASE_BITS-1:0] rd_phase
);

  localparam int W = INDEX_BITS + PHASE_BITS;

  logic [W-1:0] mem_r;
  logic [W-1:0] rd_data_r;
  logic         valid_r;

  // entry reads as zero until first written after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r <= {wr_idx, wr_phase};
    end
    if (rd_en) begin
      if (wr_en) begin
        rd_data_r <= {wr_idx, wr_phase};
      end else if (valid_r) begin
        rd_data_r <= mem_r;
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_idx   = rd_data_r[W-1:PHASE_BITS];
  assign rd_phase = rd_data_r[PHASE_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/stfe_sine_rom.sv
`default_nettype none

module stfe_sine_rom import stfe_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
  output logic signed [SAMPLE_W-1:0]               data
);

  // sin((pi/2) * r / depth) * 32767, rounded; Taylor series in Q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * r) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    v    = (sum * 64'(PEAK) + (64'd1 << 29)) >> 30;
    if (v > 64'(PEAK)) begin
      v = 64'(PEAK);
    end
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    num = 64'(k) << 2;
    q   = num / 64'(SINE_TABLE_DEPTH);
    r   = num - q * 64'(SINE_TABLE_DEPTH);
    m   = q[0] ? quarter_sine(64'(SINE_TABLE_DEPTH) - r) : quarter_sine(r);
    return q[1] ? -SAMPLE_W'(m) : SAMPLE_W'(m);
  endfunction

  logic signed [SAMPLE_W-1:0] rom_tbl [SINE_TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] data_r;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic signed [SAMPLE_W-1:0] V = sine_entry(k);
    assign rom_tbl[k] = V;
  end

  always_ff @(posedge clk) begin
    data_r <= rom_tbl[addr];
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: sv/stfe_div.sv
`default_nettype none

module stfe_div import stfe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [GAIN_W-1:0]     divisor,
  output logic                       done,
  output logic      [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  // restoring division, one quotient bit per cycle; the caller guarantees
  // the upper half of the dividend is below the divisor
  logic [QUOT_W-1:0] rem_r;
  logic [QUOT_W-1:0] lo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [QUOT_W:0]   trial;
  logic [QUOT_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, lo_r[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend[DIVIDEND_W-1:QUOT_W];
        lo_r   <= dividend[QUOT_W-1:0];
        cnt_r  <= CNT_W'(QUOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];
        lo_r  <= {lo_r[QUOT_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule

`default_nettype wire

// File: sv/sine_tone_with_fade_envelope_unit.sv
// Sine tone generator with linear fade envelope. Each input item is one
// sample tick of the current note; ticks at or past note_len give no result,
// all others give one signed sample scaled by the clamped Q1.15 amplitude
// and by min(fade-in, fade-out) over fade_len samples. Items are handled one
// at a time. A tick past the note ends after the load step; a sample with
// fade_len zero runs the load, address, ROM read, magnitude, multiply and
// output steps; a sample with the envelope active also runs the bit-serial
// envelope divider (a start step, 16 quotient bits, a step to collect). A
// result still waiting in the output register holds the block in its last
// step until the result is taken. Index and phase live in a one-entry state
// memory with a registered read; the sine table is a ROM with a registered
// read. No clearing pass runs after reset. A new item is taken as soon as the
// previous result sits in the output register, even if that result has not
// yet been taken. Configuration (amplitude at byte 0, fade_len at byte 4)
// the user must write only while idle; the block itself does not enforce it.
`default_nettype none

module sine_tone_with_fade_envelope_unit import stfe_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int INDEX_BITS       = INDEX_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [REG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW         = $clog2(SINE_TABLE_DEPTH);
  localparam int CW         = (INDEX_BITS > NOTE_LEN_W) ? INDEX_BITS : NOTE_LEN_W;
  localparam int APROD_W    = PHASE_BITS + AW + 1;
  localparam int ADDR_SHIFT = PHASE_BITS - PHASE_DROP;
  localparam int AM_W       = GAIN_W + MAG_W;
  localparam int PROD_W     = AM_W + GAIN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ADDR, S_ROMRD, S_MAG, S_MUL, S_DIVST, S_DIV, S_OUT
  } seq_t;

  // configuration
  logic [GAIN_W-1:0] amp_r;
  logic [GAIN_W-1:0] fade_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r  <= FULL_SCALE;
      fade_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AMPLITUDE: amp_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_FADE_LEN:  fade_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AMPLITUDE: cfg_prdata = 32'(amp_r);
      REG_FADE_LEN:  cfg_prdata = 32'(fade_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  seq_t                       state_r;
  in_item_t                   item_r;
  logic [INDEX_BITS-1:0]      idx_r;
  logic [PHASE_BITS-1:0]      ph_r;
  logic [AW-1:0]              addr_r;
  logic [GAIN_W-1:0]          env_r;
  logic                       last_r;
  logic                       neg_r;
  logic [AM_W-1:0]            am_r;
  logic [PROD_W-1:0]          prod_r;
  logic [QUOT_W-1:0]          res_r;
  logic                       out_valid_r;
  out_item_t                  out_item_r;

  // state memory
  logic                  mem_rd_en;
  logic                  mem_wr_en;
  logic [INDEX_BITS-1:0] mem_wr_idx;
  logic [PHASE_BITS-1:0] mem_wr_ph;
  logic [INDEX_BITS-1:0] mem_rd_idx;
  logic [PHASE_BITS-1:0] mem_rd_ph;

  logic [INDEX_BITS-1:0] idx_cur;
  logic [PHASE_BITS-1:0] ph_cur;
  logic                  live;
  logic [INDEX_BITS-1:0] idx_inc;
  logic [PHASE_BITS-1:0] ph_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign mem_rd_en = in_valid && in_ready;

  // a new note restarts index and phase before the tick is handled
  assign idx_cur = item_r.first_of_note ? '0 : mem_rd_idx;
  assign ph_cur  = item_r.first_of_note ? '0 : mem_rd_ph;
  assign live    = CW'(idx_cur) < CW'(item_r.note_len);
  assign idx_inc = (&idx_r) ? idx_r : idx_r + 1'b1;
  assign ph_inc  = ph_r + PHASE_BITS'(item_r.phase_step);

  assign mem_wr_en  = (state_r == S_LOAD && !live) || (state_r == S_ADDR);
  assign mem_wr_idx = (state_r == S_ADDR) ? idx_inc : idx_cur;
  assign mem_wr_ph  = (state_r == S_ADDR) ? ph_inc : ph_cur;

  stfe_state_mem #(
    .INDEX_BITS (INDEX_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd_en),
    .wr_en    (mem_wr_en),
    .wr_idx   (mem_wr_idx),
    .wr_phase (mem_wr_ph),
    .rd_idx   (mem_rd_idx),
    .rd_phase (mem_rd_ph)
  );

  // table address and envelope
  logic [PHASE_BITS-1:0] ph_hi;
  logic [APROD_W-1:0]    addr_prod;
  logic [APROD_W-1:0]    addr_scaled;
  logic [AW-1:0]         addr_nxt;
  logic [CW-1:0]         i_ext;
  logic [CW-1:0]         n_ext;
  logic [CW-1:0]         f_ext;
  logic [CW-1:0]         tail;
  logic [GAIN_W-1:0]     env_in;
  logic [GAIN_W-1:0]     env_nxt;

  assign ph_hi       = ph_r >> PHASE_DROP;
  assign addr_prod   = APROD_W'(ph_hi) * APROD_W'(SINE_TABLE_DEPTH);
  assign addr_scaled = addr_prod >> ADDR_SHIFT;
  assign addr_nxt    = (addr_scaled >= APROD_W'(SINE_TABLE_DEPTH)) ?
                       AW'(SINE_TABLE_DEPTH - 1) : AW'(addr_scaled);

  assign i_ext   = CW'(idx_r);
  assign n_ext   = CW'(item_r.note_len);
  assign f_ext   = CW'(fade_r);
  assign tail    = n_ext - i_ext - CW'(1);
  assign env_in  = (i_ext < f_ext) ? GAIN_W'(idx_r) : fade_r;
  assign env_nxt = (tail < f_ext && tail < CW'(env_in)) ? GAIN_W'(tail) : env_in;

  logic signed [SAMPLE_W-1:0] rom_q;

  stfe_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .addr (addr_r),
    .data (rom_q)
  );

  // magnitude and gain
  logic              silent;
  logic [MAG_W-1:0]  mag;
  logic [GAIN_W-1:0] amp_c;

  assign silent = (item_r.phase_step == '0);
  assign mag    = silent ? '0 :
                  (rom_q[SAMPLE_W-1] ? MAG_W'(-rom_q) : MAG_W'(rom_q));
  assign amp_c  = (amp_r > FULL_SCALE) ? FULL_SCALE : amp_r;

  // envelope divide
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [DIVIDEND_W-1:0] div_dividend;

  assign div_start    = (state_r == S_DIVST);
  assign div_dividend = DIVIDEND_W'(prod_r >> Q_FRAC);

  stfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fade_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  logic [QUOT_W-1:0] res_c;
  logic              out_free;

  assign res_c    = (res_r > PEAK) ? PEAK : res_r;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the output step refills the register itself when it is taken
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          idx_r   <= idx_cur;
          ph_r    <= ph_cur;
          state_r <= live ? S_ADDR : S_IDLE;
        end
        S_ADDR: begin
          addr_r  <= addr_nxt;
          env_r   <= env_nxt;
          last_r  <= (tail == '0);
          state_r <= S_ROMRD;
        end
        S_ROMRD: begin
          state_r <= S_MAG;
        end
        S_MAG: begin
          neg_r   <= !silent && rom_q[SAMPLE_W-1];
          am_r    <= AM_W'(amp_c) * AM_W'(mag);
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (fade_r == '0) begin
            res_r   <= QUOT_W'(am_r >> Q_FRAC);
            state_r <= S_OUT;
          end else begin
            prod_r  <= PROD_W'(am_r) * PROD_W'(env_r);
            state_r <= S_DIVST;
          end
        end
        S_DIVST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_item_r.sample       <= neg_r ? -$signed(res_c) : $signed(res_c);
            out_item_r.last_of_note <= last_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.sample != 16'sh8000)
    else $error("sample left the symmetric range");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_state_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> state_r == S_LOAD || state_r == S_ADDR)
    else $error("state memory written outside its update slots");

endmodule

`default_nettype wire
